@@ design/pbrl_pkg.sv @@
package pbrl_pkg;

  // Defaults for the top-level parameters
  localparam int PBRL_NUM_PRIORITIES = 64;
  localparam int PBRL_HANDLE_BITS    = 32;

  // Fixed geometry of the two-level bitmap: up to eight groups of eight
  localparam int MAX_GROUPS = 8;
  localparam int GROUP_SIZE = 8;

  // Action codes; the unused code 3 behaves as a query
  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;

  typedef logic [GROUP_SIZE-1:0] group_bits_t;

  // Update command into the bitmap; add and remove are already qualified
  typedef struct packed {
    logic       add;
    logic       remove;
    logic [2:0] row;
    logic [2:0] col;
  } bm_cmd_t;

  // Bitmap status back to the pipeline
  typedef struct packed {
    logic       hit;   // addressed slot is ready before the update
    logic [5:0] best;  // lowest ready priority, 0 when none
    logic       any;   // some priority is ready
  } bm_status_t;

  // Index of the lowest set bit; 0 for a zero byte
  function automatic logic [2:0] lowest_bit(input group_bits_t v);
    logic [2:0] idx;
    idx = 3'd0;
    for (int i = GROUP_SIZE - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = 3'(i);
      end
    end
    return idx;
  endfunction

endpackage

@@ design/priority_bitmap_ready_list_unit.sv @@
// Ready list for up to NUM_PRIORITIES task priorities (lower number is more
// urgent), kept as a two-level bitmap of eight-bit groups plus a group
// summary byte, with a HANDLE_BITS-wide task handle per priority slot held in
// a single-port-write, registered-read RAM. Each input item is an add (mark
// ready, store handle; an occupied slot is overwritten), a remove (return the
// stored handle, clear the ready bit and the group bit once the group empties)
// or a query (code 2, and also the unused code 3). A priority at or above
// NUM_PRIORITIES changes nothing. Every item yields exactly one result: the
// removed handle (0 unless a remove hit a ready slot), the lowest ready
// priority after the update (0 when nothing is ready) and an any-ready flag.
// The block takes one item per cycle while its output is not stalled; the
// RAM read registers at the accept edge and the output register loads once
// the read stage can advance, and the result is then offered.
// The ready bits double as the RAM's valid bits, so reset clears the whole
// list at once and no clearing pass is needed.
module priority_bitmap_ready_list_unit
  import pbrl_pkg::*;
#(
  parameter int NUM_PRIORITIES = PBRL_NUM_PRIORITIES,
  parameter int HANDLE_BITS    = PBRL_HANDLE_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [1:0] action, [7:2] priority_req, [39:8] task_handle
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,
  // out_tdata: [31:0] removed_handle, [37:32] best_priority, [38] any_ready,
  //            [39] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata
);

  localparam int ADDR_BITS = $clog2(NUM_PRIORITIES);

  // Input item fields
  logic [1:0]  in_action;
  logic [5:0]  in_priority_req;
  logic [31:0] in_task_handle;

  logic in_accept;
  logic slot_valid;

  bm_cmd_t    bm_cmd;
  bm_status_t bm_status;

  logic [HANDLE_BITS-1:0] ram_rd_data;

  // Read stage: the item whose handle read is in flight
  logic s1_valid_r, s1_valid_nxt;
  logic s1_hit_r;
  logic s1_adv;

  // Output register
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_removed_handle_r;
  logic [5:0]  out_best_priority_r;
  logic        out_any_ready_r;

  assign in_action       = in_tdata[1:0];
  assign in_priority_req = in_tdata[7:2];
  assign in_task_handle  = in_tdata[39:8];

  // Advance the read stage when the output register is free or being taken;
  // take a new item whenever the read stage empties in the same cycle.
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_accept = in_tvalid && in_tready;

  // Out-of-range priorities act as queries
  assign slot_valid = ({1'b0, in_priority_req} < 7'(NUM_PRIORITIES));

  // The bitmap updates at the accept edge; later items see it at once
  always_comb begin
    bm_cmd.add    = in_accept && slot_valid && (in_action == ACT_ADD);
    bm_cmd.remove = in_accept && slot_valid && (in_action == ACT_REMOVE);
    bm_cmd.row    = in_priority_req[5:3];
    bm_cmd.col    = in_priority_req[2:0];
  end

  pbrl_bitmap #(
    .NUM_PRIORITIES(NUM_PRIORITIES)
  ) u_bitmap (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (bm_cmd),
    .status(bm_status)
  );

  // Handle store. A remove needs no write-back: the cleared ready bit marks
  // the entry empty, and an empty entry reads as the null handle.
  pbrl_ram #(
    .WIDTH(HANDLE_BITS),
    .DEPTH(NUM_PRIORITIES)
  ) u_handle_ram (
    .clk    (clk),
    .wr_en  (bm_cmd.add),
    .wr_addr(in_priority_req[ADDR_BITS-1:0]),
    .wr_data(HANDLE_BITS'(in_task_handle)),
    .rd_en  (in_accept),
    .rd_addr(in_priority_req[ADDR_BITS-1:0]),
    .rd_data(ram_rd_data)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold whether this remove found its slot ready, i.e. the RAM data is live
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_hit_r <= bm_cmd.remove && bm_status.hit;
    end
  end

  // Bitmap status seen here already includes the read-stage item's update
  // and nothing later, since no new item lands before this edge.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_removed_handle_r <= s1_hit_r ? 32'(ram_rd_data) : '0;
      out_best_priority_r  <= bm_status.best;
      out_any_ready_r      <= bm_status.any;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_any_ready_r, out_best_priority_r, out_removed_handle_r};

endmodule

@@ design/pbrl_ram.sv @@
module pbrl_ram
  import pbrl_pkg::*;
#(
  parameter int WIDTH = PBRL_HANDLE_BITS,
  parameter int DEPTH = PBRL_NUM_PRIORITIES
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; hold the last data while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ design/pbrl_bitmap.sv @@
module pbrl_bitmap
  import pbrl_pkg::*;
#(
  parameter int NUM_PRIORITIES = PBRL_NUM_PRIORITIES
) (
  input  logic       clk,
  input  logic       rst_n,
  input  bm_cmd_t    cmd,
  output bm_status_t status
);

  localparam int NUM_GROUPS = (NUM_PRIORITIES + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam logic [MAX_GROUPS-1:0] GROUP_MASK = MAX_GROUPS'((1 << NUM_GROUPS) - 1);

  group_bits_t [MAX_GROUPS-1:0] ready_r, ready_nxt;
  logic [MAX_GROUPS-1:0]        summary_r, summary_nxt;

  group_bits_t row_bits;
  group_bits_t row_new;
  group_bits_t col_onehot;
  logic [2:0]  grp;

  always_comb begin
    row_bits   = ready_r[cmd.row];
    col_onehot = group_bits_t'(1) << cmd.col;
    row_new    = row_bits;
    if (cmd.add) begin
      row_new = row_bits | col_onehot;
    end else if (cmd.remove) begin
      row_new = row_bits & ~col_onehot;
    end

    ready_nxt   = ready_r;
    summary_nxt = summary_r;
    if (cmd.add || cmd.remove) begin
      ready_nxt[cmd.row] = row_new;
    end
    if (cmd.add) begin
      summary_nxt[cmd.row] = 1'b1;
    end else if (cmd.remove && (row_new == '0)) begin
      summary_nxt[cmd.row] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r   <= '0;
      summary_r <= '0;
    end else begin
      ready_r   <= ready_nxt;
      summary_r <= summary_nxt;
    end
  end

  // Two-level encode over the registered bitmap
  always_comb begin
    grp         = lowest_bit(summary_r & GROUP_MASK);
    status.hit  = row_bits[cmd.col];
    status.best = {grp, lowest_bit(ready_r[grp])};
    status.any  = |summary_r;
  end

endmodule

@@ tb/priority_bitmap_ready_list_checker.sv @@
module priority_bitmap_ready_list_checker
  import pbrl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [1:0] action, [7:2] priority_req, [39:8] task_handle
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,
  // out_tdata: [31:0] removed_handle, [37:32] best_priority, [38] any_ready,
  //            [39] zero
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  output int          results_checked,
  output int          mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] removed_handle;
    logic [5:0]  best_priority;
    logic        any_ready;
  } ready_list_outcome_t;

  group_bits_t                 ready_rows [MAX_GROUPS];
  group_bits_t                 group_summary_bits;
  logic [31:0]                 slot_handles [PBRL_NUM_PRIORITIES];
  ready_list_outcome_t         pending_outcomes [$];
  ready_list_outcome_t         want;
  int                          n_checked;
  int                          n_bad;

  function automatic logic [2:0] lowest_ready(input group_bits_t bits);
    logic [2:0] pos;
    logic       found;
    pos   = 3'd0;
    found = 1'b0;
    for (int i = 0; i < GROUP_SIZE; i++) begin
      if (bits[i] && !found) begin
        pos   = 3'(i);
        found = 1'b1;
      end
    end
    return pos;
  endfunction

  // Update the list for one item and return the result it must produce
  function automatic ready_list_outcome_t apply_ready_list_item(
    input logic [1:0]  act,
    input logic [5:0]  prio,
    input logic [31:0] handle
  );
    ready_list_outcome_t res;
    logic [2:0]          row;
    logic [2:0]          col;
    logic [2:0]          grp;
    logic                in_range;
    res      = '0;
    row      = prio[5:3];
    col      = prio[2:0];
    in_range = int'(prio) < PBRL_NUM_PRIORITIES;
    if (in_range && act == ACT_ADD) begin
      ready_rows[row][col]    = 1'b1;
      group_summary_bits[row] = 1'b1;
      slot_handles[prio]      = handle;
    end else if (in_range && act == ACT_REMOVE) begin
      res.removed_handle   = slot_handles[prio];
      ready_rows[row][col] = 1'b0;
      if (ready_rows[row] == '0) begin
        group_summary_bits[row] = 1'b0;
      end
      slot_handles[prio] = '0;
    end
    grp               = lowest_ready(group_summary_bits);
    res.best_priority = {grp, lowest_ready(ready_rows[grp])};
    res.any_ready     = |group_summary_bits;
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (ready_rows[r]) ready_rows[r] = '0;
      foreach (slot_handles[p]) slot_handles[p] = '0;
      group_summary_bits = '0;
      pending_outcomes.delete();
      n_checked = 0;
      n_bad     = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_outcomes.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %h", $time, out_tdata);
          n_bad++;
        end else begin
          want = pending_outcomes.pop_front();
          n_checked++;
          if (out_tdata[31:0] !== want.removed_handle) begin
            $display("%0t: removed_handle: expected %h, actual %h",
                     $time, want.removed_handle, out_tdata[31:0]);
            n_bad++;
          end
          if (out_tdata[37:32] !== want.best_priority) begin
            $display("%0t: best_priority: expected %0d, actual %0d",
                     $time, want.best_priority, out_tdata[37:32]);
            n_bad++;
          end
          if (out_tdata[38] !== want.any_ready) begin
            $display("%0t: any_ready: expected %b, actual %b",
                     $time, want.any_ready, out_tdata[38]);
            n_bad++;
          end
          if (out_tdata[39] !== 1'b0) begin
            $display("%0t: pad bit: expected 0, actual %b", $time, out_tdata[39]);
            n_bad++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        pending_outcomes.push_back(
          apply_ready_list_item(in_tdata[1:0], in_tdata[7:2], in_tdata[39:8]));
      end
    end
    results_checked <= n_checked;
    mismatches      <= n_bad;
  end

endmodule

@@ tb/priority_bitmap_ready_list_unit_tb.sv @@
module priority_bitmap_ready_list_unit_tb
  import pbrl_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // The package names the three live action codes; the spare one acts as a query
  localparam logic [1:0] ACT_SPARE = 2'd3;

  localparam int RANDOM_ITEMS   = 1400;
  localparam int WATCHDOG_LIMIT = 4000;
  // Receiver holds off this long once, after this many results
  localparam int LONG_HOLD      = 300;
  localparam int LONG_HOLD_AT   = 500;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;

  int          results_checked;
  int          mismatches;
  int          items_sent = 0;
  int          quiet_cycles = 0;
  // Priorities the stimulus believes are ready; steers removes onto live slots
  logic [63:0] ready_shadow = '0;

  always #2 clk = ~clk;

  priority_bitmap_ready_list_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  priority_bitmap_ready_list_checker ready_list_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .results_checked (results_checked),
    .mismatches      (mismatches)
  );

  // Mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // Offer one item and hold it until the block takes it
  task automatic offer_item(input logic [1:0] act, input logic [5:0] prio,
                            input logic [31:0] handle);
    in_tvalid <= 1'b1;
    in_tdata  <= {handle, prio, act};
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (act == ACT_ADD) begin
      ready_shadow[prio] = 1'b1;
    end else if (act == ACT_REMOVE) begin
      ready_shadow[prio] = 1'b0;
    end
  endtask

  // Drop valid while idling; scramble the data bus meanwhile
  task automatic idle_sender(input int cycles);
    in_tvalid <= 1'b0;
    in_tdata  <= {8'($urandom), 32'($urandom)};
    repeat (cycles) @(posedge clk);
  endtask

  // Stop offering until every result owed has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (items_sent != results_checked);
  endtask

  // Watchdog: end the run if neither side moves an item for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

  // Result side: random runs of ready and stalls, plus one long hold-off
  // so the block backs up and stalls its input
  initial begin : receiver
    int hold_left;
    int run_left;
    int taken;
    bit long_hold_done;
    hold_left      = 0;
    run_left       = 0;
    taken          = 0;
    long_hold_done = 1'b0;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (out_tvalid && out_tready) taken++;
      if (!long_hold_done && taken >= LONG_HOLD_AT) begin
        long_hold_done = 1'b1;
        hold_left      = LONG_HOLD;
        run_left       = 0;
      end
      if (hold_left == 0 && run_left == 0) begin
        // Now and then a long stretch with no stall at all
        run_left  = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                : $urandom_range(1, 20);
        hold_left = pick_gap();
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= 1'b1;
        run_left--;
      end
      @(posedge clk);
    end
  end

  // Input side: directed items, then a random scheduler workload
  initial begin : stimulus
    int          start;
    int          gap;
    int          add_pct;
    bit          gaps_on;
    bit          found;
    logic [1:0]  act;
    logic [5:0]  prio;
    logic [31:0] handle;
    logic [2:0]  focus_row;
    gaps_on   = 1'b1;
    add_pct   = 50;
    focus_row = 3'd0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty list: query, remove of an empty slot, the spare code
    offer_item(ACT_QUERY,  6'd0,  32'hFFFF_FFFF);
    offer_item(ACT_REMOVE, 6'd0,  32'hFFFF_FFFF);
    offer_item(ACT_SPARE,  6'd63, 32'h0000_0000);
    // Both ends of the priority range, then overwrite an occupied slot
    offer_item(ACT_ADD,    6'd63, 32'hFFFF_FFFF);
    offer_item(ACT_ADD,    6'd0,  32'h0000_0000);
    offer_item(ACT_ADD,    6'd0,  32'hA5A5_A5A5);
    offer_item(ACT_REMOVE, 6'd0,  32'h0000_0000);
    // Group boundaries
    offer_item(ACT_ADD,    6'd7,  32'h5A5A_5A5A);
    offer_item(ACT_ADD,    6'd8,  32'h1234_5678);
    offer_item(ACT_ADD,    6'd56, 32'h0F0F_0F0F);
    offer_item(ACT_SPARE,  6'd40, 32'hFFFF_FFFF);
    // Remove twice: the second hits an empty slot
    offer_item(ACT_REMOVE, 6'd63, 32'h0000_0000);
    offer_item(ACT_REMOVE, 6'd63, 32'hFFFF_FFFF);
    // Walk the best priority up until nothing is ready
    offer_item(ACT_REMOVE, 6'd7,  32'h0000_0000);
    offer_item(ACT_REMOVE, 6'd8,  32'h0000_0000);
    offer_item(ACT_REMOVE, 6'd56, 32'h0000_0000);
    offer_item(ACT_ADD,    6'd0,  32'hFFFF_FFFF);
    offer_item(ACT_REMOVE, 6'd0,  32'h0000_0000);
    // Group stays set while a member is left, clears with the last one
    offer_item(ACT_ADD,    6'd15, 32'h0000_0001);
    offer_item(ACT_ADD,    6'd9,  32'h8000_0000);
    offer_item(ACT_REMOVE, 6'd9,  32'h0000_0000);
    offer_item(ACT_REMOVE, 6'd15, 32'h0000_0000);
    offer_item(ACT_QUERY,  6'd21, 32'h0000_0000);
    drain_results();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // Re-shape the workload every hundred items: fill or drain the list,
      // favor one group, and sometimes send back to back
      if (i % 100 == 0) begin
        gaps_on   = ($urandom_range(0, 3) != 0);
        add_pct   = $urandom_range(25, 70);
        focus_row = 3'($urandom_range(0, 7));
      end
      // Pause midway until every result is back
      if (i == RANDOM_ITEMS / 2) drain_results();

      handle = 32'($urandom);
      if ($urandom_range(0, 99) < add_pct) begin
        act = ACT_ADD;
        if ($urandom_range(0, 99) < 30) begin
          prio = {focus_row, 3'($urandom_range(0, 7))};
        end else begin
          prio = 6'($urandom_range(0, 63));
        end
        case ($urandom_range(0, 9))
          0: handle = 32'h0000_0000;
          1: handle = 32'hFFFF_FFFF;
          default: ;
        endcase
      end else if ($urandom_range(0, 3) != 0) begin
        act  = ACT_REMOVE;
        prio = 6'($urandom_range(0, 63));
        // Mostly remove a live slot; the rest hit whatever is there
        if ($urandom_range(0, 99) < 85) begin
          start = $urandom_range(0, 63);
          found = 1'b0;
          for (int k = 0; k < 64 && !found; k++) begin
            if (ready_shadow[6'(start + k)]) begin
              prio  = 6'(start + k);
              found = 1'b1;
            end
          end
        end
      end else begin
        act  = $urandom_range(0, 1) ? ACT_QUERY : ACT_SPARE;
        prio = 6'($urandom_range(0, 63));
      end

      gap = gaps_on ? pick_gap() : 0;
      if (gap > 0) idle_sender(gap);
      offer_item(act, prio, handle);
    end

    drain_results();
    // Let any stray result show up before the verdict
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
